// ===== src/skit_pkg.sv =====
// Shared types and constants for the sorted key index table.
// Holds the port word structs, operation and status codes, and the
// command/status structs between the controller and the datapath.
package skit_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DELETED   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] key;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_slot;
        logic       slot_active;
        logic [4:0] entry_count;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic ins_start;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic srch_start;
        logic probe_read;
        logic probe_hit;
        logic go_up;
        logic go_down;
        logic finish_hit;
        logic set_full;
        logic set_miss;
        logic emit;
    } skit_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       table_full;
        logic       pos_zero;
        logic       ins_gt;
        logic       srch_open;
        logic       probe_eq;
        logic       probe_up;
        logic       out_free;
    } skit_stat_t;

endpackage

// ===== src/sorted_key_index_table_core.sv =====
// Channel   Direction  Word         Handshake
// s_        in         in_word_t    s_valid / s_ready
// m_        out        out_word_t   m_valid / m_ready
//
// One word at a time. Insert shifts each of the k larger keys up one place
// through the single read/write port pair of the index memory, then places
// the new key. Lookup and delete make p midpoint probes (p at most
// log2(TABLE_DEPTH) + 1). The next word can be taken in the cycle after the
// result is loaded into the output register.
// Reset empties the table at once; no clearing pass is needed. A finished
// result waits while the output register still holds an unaccepted word.
//
// Top level of the sorted key index table; depends on skit_pkg,
// skit_ctrl and skit_dpath.
module sorted_key_index_table_core
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    skit_cmd_t  cmd;
    skit_stat_t stat;

    skit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    skit_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

// ===== src/skit_ctrl.sv =====
// Controller state machine of the sorted key index table.
// Depends on skit_pkg for the command and status structs.
module skit_ctrl
    import skit_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  skit_stat_t stat,
    output skit_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_INS_RD  = 8'b0000_0100,
        S_INS_CMP = 8'b0000_1000,
        S_SRCH    = 8'b0001_0000,
        S_PROBE   = 8'b0010_0000,
        S_ACT     = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.action == ACT_INSERT) begin
                    if (stat.table_full) begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        cmd.ins_start = 1'b1;
                        state_next    = S_INS_RD;
                    end
                end else if (stat.action inside {ACT_LOOKUP, ACT_DELETE}) begin
                    cmd.srch_start = 1'b1;
                    state_next     = S_SRCH;
                end else begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_INS_RD: begin
                if (stat.pos_zero) begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (stat.ins_gt) begin
                    cmd.ins_shift = 1'b1;
                    state_next    = S_INS_RD;
                end else begin
                    cmd.ins_place = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_SRCH: begin
                if (stat.srch_open) begin
                    cmd.probe_read = 1'b1;
                    state_next     = S_PROBE;
                end else begin
                    cmd.set_miss = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_PROBE: begin
                if (stat.probe_eq) begin
                    cmd.probe_hit = 1'b1;
                    state_next    = S_ACT;
                end else if (stat.probe_up) begin
                    cmd.go_up  = 1'b1;
                    state_next = S_SRCH;
                end else begin
                    cmd.go_down = 1'b1;
                    state_next  = S_SRCH;
                end
            end
            S_ACT: begin
                cmd.finish_hit = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/skit_dpath.sv =====
// Datapath of the sorted key index table: index memories, active marks,
// search bounds, insert pointer and the output register.
// Depends on skit_pkg for port words, codes and the command/status structs.
module skit_dpath
    import skit_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data,
    input  skit_cmd_t  cmd,
    output skit_stat_t stat
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Index memories and active marks. Only entries below the used count
    // are ever read, and every one of those has been written by an insert.
    logic [KEY_BITS-1:0] key_mem  [TABLE_DEPTH];
    logic [IDX_W-1:0]    slot_mem [TABLE_DEPTH];
    logic                act_mem  [TABLE_DEPTH];

    logic [KEY_BITS-1:0] rd_key_reg;
    logic [IDX_W-1:0]    rd_slot_reg;
    logic                rd_act_reg;

    logic [1:0]          action_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hip_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [1:0]          res_status_reg;
    logic                res_active_reg;
    out_word_t           m_data_reg;
    logic                m_valid_reg;

    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [CNT_W:0]      mid_sum;
    logic [CNT_W:0]      mid_half;
    logic [IDX_W-1:0]    mid_calc;
    logic [CNT_W-1:0]    pos_m1;
    logic                ent_we;
    logic [IDX_W-1:0]    ent_waddr;
    logic [KEY_BITS-1:0] ent_wkey;
    logic [IDX_W-1:0]    ent_wslot;
    logic                ent_re;
    logic [IDX_W-1:0]    ent_raddr;
    logic                act_we;
    logic [IDX_W-1:0]    act_waddr;
    logic                act_wdata;
    logic [31:0]         slot_ext;
    logic [31:0]         cnt_ext;

    assign key_wide = 64'(s_data.key);
    assign key_in   = key_wide[KEY_BITS-1:0];

    // Midpoint of lo and hi, where hip_reg holds hi plus one.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hip_reg} - 1'b1;
    assign mid_half = mid_sum >> 1;
    assign mid_calc = mid_half[IDX_W-1:0];
    assign pos_m1   = pos_reg - 1'b1;

    always_comb begin
        ent_we    = cmd.ins_shift | cmd.ins_place;
        ent_waddr = pos_reg[IDX_W-1:0];
        ent_wkey  = cmd.ins_shift ? rd_key_reg : key_reg;
        ent_wslot = cmd.ins_shift ? rd_slot_reg : used_reg[IDX_W-1:0];
        ent_re    = cmd.ins_read | cmd.probe_read;
        ent_raddr = cmd.ins_read ? pos_m1[IDX_W-1:0] : mid_calc;
        act_we    = cmd.ins_start | (cmd.finish_hit & (action_reg == ACT_DELETE) & rd_act_reg);
        act_waddr = cmd.ins_start ? used_reg[IDX_W-1:0] : slot_reg;
        act_wdata = cmd.ins_start;
    end

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            key_mem[ent_waddr]  <= ent_wkey;
            slot_mem[ent_waddr] <= ent_wslot;
        end
        if (ent_re) begin
            rd_key_reg  <= key_mem[ent_raddr];
            rd_slot_reg <= slot_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (act_we) begin
            act_mem[act_waddr] <= act_wdata;
        end
        if (cmd.probe_hit) begin
            rd_act_reg <= act_mem[rd_slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= s_data.action;
            key_reg    <= key_in;
        end
        if (cmd.ins_start) begin
            pos_reg  <= used_reg;
            slot_reg <= used_reg[IDX_W-1:0];
        end
        if (cmd.ins_shift) begin
            pos_reg <= pos_m1;
        end
        if (cmd.ins_place) begin
            res_status_reg <= ST_OK;
            res_active_reg <= 1'b1;
        end
        if (cmd.srch_start) begin
            lo_reg  <= '0;
            hip_reg <= used_reg;
        end
        if (cmd.go_up) begin
            lo_reg <= CNT_W'(pos_reg) + 1'b1;
        end
        if (cmd.go_down) begin
            hip_reg <= pos_reg;
        end
        if (cmd.probe_read) begin
            pos_reg <= CNT_W'(mid_calc);
        end
        if (cmd.probe_hit) begin
            slot_reg <= rd_slot_reg;
        end
        if (cmd.finish_hit) begin
            if (action_reg == ACT_LOOKUP) begin
                res_status_reg <= ST_OK;
                res_active_reg <= rd_act_reg;
            end else begin
                res_status_reg <= rd_act_reg ? ST_OK : ST_DELETED;
                res_active_reg <= 1'b0;
            end
        end
        if (cmd.set_full | cmd.set_miss) begin
            res_status_reg <= cmd.set_full ? ST_FULL : ST_NOT_FOUND;
            res_active_reg <= 1'b0;
            slot_reg       <= '0;
        end
        if (cmd.emit) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.found_slot  <= slot_ext[3:0];
            m_data_reg.slot_active <= res_active_reg;
            m_data_reg.entry_count <= cnt_ext[4:0];
        end
    end

    assign slot_ext = 32'(slot_reg);
    assign cnt_ext  = 32'(used_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ins_place) begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        stat.action     = action_reg;
        stat.table_full = (used_reg == CNT_W'(TABLE_DEPTH));
        stat.pos_zero   = (pos_reg == '0);
        stat.ins_gt     = (rd_key_reg > key_reg);
        stat.srch_open  = (lo_reg < hip_reg);
        stat.probe_eq   = (rd_key_reg == key_reg);
        stat.probe_up   = (key_reg > rd_key_reg);
        stat.out_free   = ~m_valid_reg | m_ready;
    end

endmodule
